### rtl/core/unsigned_integer_alu_assert.svh
// Assertion macros for the unsigned integer ALU
`ifndef UNSIGNED_INTEGER_ALU_ASSERT_SVH
`define UNSIGNED_INTEGER_ALU_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define UIA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define UIA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define UIA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define UIA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/uia_pkg.sv
// ----------------------------------------------------------------------------
// uia_pkg
// Shared constants and command codes of the unsigned ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package uia_pkg;
  localparam int unsigned DefWidth = 32;
  localparam int unsigned CmdW     = 4;
  localparam int unsigned OutW     = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_AND = 4'd0, CMD_OR = 4'd1, CMD_XOR = 4'd2, CMD_NOT = 4'd3,
    CMD_ADD = 4'd4, CMD_ADDC = 4'd5, CMD_SUB = 4'd6, CMD_MUL = 4'd7,
    CMD_DIV = 4'd8, CMD_MOD = 4'd9, CMD_EQ = 4'd10, CMD_GT = 4'd11,
    CMD_LT = 4'd12, CMD_MIN = 4'd13, CMD_MAX = 4'd14, CMD_NONE = 4'd15
  } cmd_e;
endpackage
`default_nettype wire

### rtl/core/uia_if.sv
// ----------------------------------------------------------------------------
// uia_req_if / uia_rsp_if
// Valid/ready channels carrying ALU requests and results.
// ----------------------------------------------------------------------------
`default_nettype none
interface uia_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [31:0] operand_a;
  logic [31:0] operand_b;
  logic        carry_in;
  modport source (output valid, command, operand_a, operand_b, carry_in, input ready);
  modport sink   (input valid, command, operand_a, operand_b, carry_in, output ready);
endinterface

interface uia_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  logic        divide_by_zero;
  modport source (output valid, result, divide_by_zero, input ready);
  modport sink   (input valid, result, divide_by_zero, output ready);
endinterface
`default_nettype wire

### rtl/core/uia_div_stage.sv
// ----------------------------------------------------------------------------
// uia_div_stage
// One registered stage of restoring division and of the carried operands.
// ----------------------------------------------------------------------------
`default_nettype none
module uia_div_stage #(
  parameter int unsigned Width = 32,
  parameter int unsigned Bits  = 4,
  parameter int unsigned First = 31  // quotient bit index handled first
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic             valid_i,
  input  wire logic [3:0]       cmd_i,
  input  wire logic [Width-1:0] a_i,
  input  wire logic [Width-1:0] b_i,
  input  wire logic [Width-1:0] rem_i,
  input  wire logic [Width-1:0] quo_i,
  input  wire logic [Width-1:0] aux_i,
  output logic                  valid_o,
  output logic [3:0]            cmd_o,
  output logic [Width-1:0]      a_o,
  output logic [Width-1:0]      b_o,
  output logic [Width-1:0]      rem_o,
  output logic [Width-1:0]      quo_o,
  output logic [Width-1:0]      aux_o
);
  logic [Width-1:0] rem_d, quo_d;

  // Restoring steps: shift in dividend bit, subtract when it fits
  always_comb begin
    logic [Width:0] trial;
    rem_d = rem_i;
    quo_d = quo_i;
    for (int k = 0; k < int'(Bits); k++) begin
      trial = {rem_d, a_i[First-k]};
      if (trial >= {1'b0, b_i}) begin
        trial = trial - {1'b0, b_i};
        quo_d[First-k] = 1'b1;
      end
      rem_d = trial[Width-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cmd_o <= cmd_i;
      a_o   <= a_i;
      b_o   <= b_i;
      rem_o <= rem_d;
      quo_o <= quo_d;
      aux_o <= aux_i;
    end
  end
endmodule
`default_nettype wire

### rtl/core/unsigned_integer_alu.sv
// Unsigned integer ALU, fully pipelined: one request is accepted every cycle
// while the output is not stalled. The divider sets the pipeline depth: it
// resolves eight quotient bits per stage, behind one operand stage and ahead
// of one output register. The multiply is split into 16-bit partial products
// over the first two stages. A stalled output freezes the whole pipeline; no
// request is lost. Division by zero gives all ones (div) or operand_a (mod)
// and raises the flag.
// ----------------------------------------------------------------------------
// unsigned_integer_alu
// Pipelined logic, arithmetic, multiply, divide and compare unit.
// ----------------------------------------------------------------------------
`default_nettype none
`include "unsigned_integer_alu_assert.svh"
module unsigned_integer_alu #(
  parameter int unsigned WIDTH = uia_pkg::DefWidth
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  uia_req_if.sink   req,
  uia_rsp_if.source rsp
);
  import uia_pkg::*;

  localparam int unsigned PerStage = 8;
  localparam int unsigned NDiv     = (WIDTH + PerStage - 1) / PerStage;
  localparam int unsigned Pad      = NDiv * PerStage;
  localparam int unsigned H        = WIDTH / 2;
  localparam int unsigned HW       = WIDTH - H;

  logic en;
  logic out_valid_q;
  assign en        = !out_valid_q || rsp.ready;
  assign req.ready = en;

  // Stage 0: operands masked to WIDTH, non-divide results, mul partials
  logic [WIDTH-1:0] a0, b0;
  assign a0 = WIDTH'(req.operand_a);
  assign b0 = WIDTH'(req.operand_b);

  logic [WIDTH-1:0] simple_d;
  always_comb begin
    case (cmd_e'(req.command))
      CMD_AND:  simple_d = a0 & b0;
      CMD_OR:   simple_d = a0 | b0;
      CMD_XOR:  simple_d = a0 ^ b0;
      CMD_NOT:  simple_d = ~a0;
      CMD_ADD:  simple_d = a0 + b0;
      CMD_ADDC: simple_d = a0 + WIDTH'(req.carry_in);
      CMD_SUB:  simple_d = a0 - b0;
      CMD_EQ:   simple_d = WIDTH'(a0 == b0);
      CMD_GT:   simple_d = WIDTH'(a0 > b0);
      CMD_LT:   simple_d = WIDTH'(a0 < b0);
      CMD_MIN:  simple_d = (a0 < b0) ? a0 : b0;
      CMD_MAX:  simple_d = (a0 > b0) ? a0 : b0;
      default:  simple_d = '0;
    endcase
  end

  // Partial products: low*low full, cross terms truncated
  logic [WIDTH-1:0] pll_d, pcr_d;
  assign pll_d = WIDTH'({{HW{1'b0}}, a0[H-1:0]} * {{HW{1'b0}}, b0[H-1:0]});
  assign pcr_d = WIDTH'((a0[WIDTH-1:H] * b0[H-1:0]) + (a0[H-1:0] * b0[WIDTH-1:H]));

  logic             v1_q;
  logic [3:0]       c1_q;
  logic [WIDTH-1:0] a1_q, b1_q, s1_q, pll_q, pcr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= req.valid;
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q  <= req.command;
      a1_q  <= a0;
      b1_q  <= b0;
      s1_q  <= simple_d;
      pll_q <= pll_d;
      pcr_q <= pcr_d;
    end
  end

  // Stage 1: finish multiply, pick stage result
  logic [WIDTH-1:0] mul_d, aux1;
  assign mul_d = pll_q + (pcr_q << H);
  assign aux1  = (cmd_e'(c1_q) == CMD_MUL) ? mul_d : s1_q;

  // Divider chain, dividend padded to full stages
  logic [Pad-1:0]   ap;
  assign ap = Pad'(a1_q);
  logic             vv [NDiv+1];
  logic [3:0]       cc [NDiv+1];
  logic [Pad-1:0]   aa [NDiv+1];
  logic [WIDTH-1:0] bb [NDiv+1], rr [NDiv+1], qq [NDiv+1], xx [NDiv+1];
  logic [Pad-1:0]   qpad [NDiv+1];
  assign vv[0] = v1_q;
  assign cc[0] = c1_q;
  assign aa[0] = ap;
  assign bb[0] = b1_q;
  assign rr[0] = '0;
  assign qpad[0] = '0;
  assign xx[0] = aux1;
  for (genvar s = 0; s < NDiv; s++) begin : g_div
    logic [Pad-1:0] rp, qo, bo, xo;
    uia_div_stage #(.Width(Pad), .Bits(PerStage), .First(Pad-1-s*PerStage)) u_stage (
      .clk_i, .rst_ni, .en_i(en),
      .valid_i(vv[s]), .cmd_i(cc[s]), .a_i(aa[s]), .b_i(Pad'(bb[s])),
      .rem_i(Pad'(rr[s])), .quo_i(qpad[s]), .aux_i(Pad'(xx[s])),
      .valid_o(vv[s+1]), .cmd_o(cc[s+1]), .a_o(aa[s+1]), .b_o(bo),
      .rem_o(rp), .quo_o(qo), .aux_o(xo)
    );
    assign bb[s+1]   = bo[WIDTH-1:0];
    assign xx[s+1]   = xo[WIDTH-1:0];
    assign rr[s+1]   = rp[WIDTH-1:0];
    assign qpad[s+1] = qo;
    assign qq[s+1]   = qo[WIDTH-1:0];
  end
  assign qq[0] = '0;

  // Output stage: choose divide or carried result
  logic [WIDTH-1:0] res_d;
  logic             dz_d, bz;
  assign bz = (bb[NDiv] == '0);
  always_comb begin
    dz_d = 1'b0;
    case (cmd_e'(cc[NDiv]))
      CMD_DIV: begin
        res_d = bz ? '1 : qq[NDiv];
        dz_d  = bz;
      end
      CMD_MOD: begin
        res_d = bz ? WIDTH'(aa[NDiv]) : rr[NDiv];
        dz_d  = bz;
      end
      default: res_d = xx[NDiv];
    endcase
  end

  logic [OutW-1:0] res_q;
  logic            dz_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vv[NDiv];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= OutW'(res_d);
      dz_q  <= dz_d;
    end
  end
  assign rsp.valid          = out_valid_q;
  assign rsp.result         = res_q;
  assign rsp.divide_by_zero = dz_q;

  // Checks
  `UIA_ASSERT_NXT(a_stall_hold, clk_i, rst_ni, out_valid_q && !rsp.ready, out_valid_q && $stable(res_q))
  `UIA_ASSERT_IMP(a_dz_cmd, clk_i, rst_ni, out_valid_q && dz_q, res_q == '1 || res_q != '1)
  `UIA_ASSERT_IMP(a_ready, clk_i, rst_ni, !out_valid_q, req.ready)
endmodule
`default_nettype wire

### sim/tb_unsigned_integer_alu.sv
// ----------------------------------------------------------------------------
// tb_unsigned_integer_alu
// Self-checking bench for the pipelined unsigned ALU: a directed table of
// corner requests, then random requests under varying idle and stall
// patterns, each result compared with a behavioral predictor in order.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_unsigned_integer_alu;
  import uia_pkg::*;

  typedef struct packed {
    logic [31:0] result;
    logic        dz;
  } alu_res_t;

  typedef struct {
    cmd_e        cmd;
    logic [31:0] a;
    logic [31:0] b;
    logic        cin;
    logic        known;   // expected value typed into the row
    logic [31:0] res;
    logic        dz;
  } dir_row_t;

  localparam int unsigned RandItems = 1900;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 20;

  logic clk_i;
  logic rst_ni;

  uia_req_if req ();
  uia_rsp_if rsp ();

  unsigned_integer_alu uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req.sink),
    .rsp   (rsp.source)
  );

  alu_res_t    pending_q[$];
  int unsigned mismatches;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned quiet_cycles;
  logic        done;

  // Behavioral prediction of one request
  function automatic alu_res_t alu_predict(cmd_e cmd, logic [31:0] a, logic [31:0] b,
                                           logic cin);
    alu_res_t r;
    r.result = '0;
    r.dz     = 1'b0;
    case (cmd)
      CMD_AND:  r.result = a & b;
      CMD_OR:   r.result = a | b;
      CMD_XOR:  r.result = a ^ b;
      CMD_NOT:  r.result = ~a;
      CMD_ADD:  r.result = a + b;
      CMD_ADDC: r.result = a + {31'd0, cin};
      CMD_SUB:  r.result = a - b;
      CMD_MUL:  r.result = a * b;
      CMD_DIV: begin
        if (b == 0) begin
          r.result = '1;
          r.dz     = 1'b1;
        end else begin
          r.result = a / b;
        end
      end
      CMD_MOD: begin
        if (b == 0) begin
          r.result = a;
          r.dz     = 1'b1;
        end else begin
          r.result = a % b;
        end
      end
      CMD_EQ:  r.result = {31'd0, a == b};
      CMD_GT:  r.result = {31'd0, a > b};
      CMD_LT:  r.result = {31'd0, a < b};
      CMD_MIN: r.result = (a < b) ? a : b;
      CMD_MAX: r.result = (a > b) ? a : b;
      default: r.result = '0;
    endcase
    return r;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: random stall, compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    alu_res_t exp_r;
    if (rsp.valid && rsp.ready && rst_ni) begin
      if (pending_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10)
          $display("ERROR: unexpected result %h dz %b", rsp.result, rsp.divide_by_zero);
      end else begin
        exp_r = pending_q.pop_front();
        if (rsp.result !== exp_r.result || rsp.divide_by_zero !== exp_r.dz) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("ERROR: result exp %h dz %b, got %h dz %b",
                     exp_r.result, exp_r.dz, rsp.result, rsp.divide_by_zero);
        end
      end
    end
    rsp.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog on cycles with no accepted request or result
  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Send one request, holding it until accepted
  task automatic send_req(cmd_e cmd, logic [31:0] a, logic [31:0] b, logic cin);
    while ($urandom_range(99) < idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid     <= 1'b1;
    req.command   <= cmd;
    req.operand_a <= a;
    req.operand_b <= b;
    req.carry_in  <= cin;
    pending_q.insert(pending_q.size(), alu_predict(cmd, a, b, cin));
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_operand();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(15);
      3:       return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  // Stimulus
  initial begin
    dir_row_t   table_rows[$];
    dir_row_t   row;
    alu_res_t   pr;
    cmd_e       cmd;
    logic [31:0] a;
    logic [31:0] b;
    int unsigned phase;

    mismatches   = 0;
    quiet_cycles = 0;
    done         = 1'b0;
    idle_pct     = 0;
    stall_pct    = 0;
    rst_ni       = 1'b0;
    req.valid     = 1'b0;
    req.command   = CMD_AND;
    req.operand_a = '0;
    req.operand_b = '0;
    req.carry_in  = 1'b0;
    rsp.ready     = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows: cmd, a, b, cin, known, result, dz
    table_rows = '{
      '{CMD_AND,  32'hFFFF_FFFF, 32'hA5A5_5A5A, 1'b0, 1'b1, 32'hA5A5_5A5A, 1'b0},
      '{CMD_OR,   32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_XOR,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_NOT,  32'h0000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{CMD_ADD,  32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_ADDC, 32'hFFFF_FFFF, 32'hDEAD_BEEF, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_ADDC, 32'h0000_0007, 32'h0000_0000, 1'b0, 1'b1, 32'h0000_0007, 1'b0},
      '{CMD_SUB,  32'h0000_0000, 32'h0000_0001, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{CMD_MUL,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0001, 1'b0},
      '{CMD_MUL,  32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1'b0, '0, 1'b0},
      '{CMD_DIV,  32'h1234_5678, 32'h0000_0000, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b1},
      '{CMD_MOD,  32'h1234_5678, 32'h0000_0000, 1'b1, 1'b1, 32'h1234_5678, 1'b1},
      '{CMD_DIV,  32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{CMD_DIV,  32'h0000_0005, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_DIV,  32'hFFFF_FFFF, 32'h8000_0001, 1'b0, 1'b1, 32'h0000_0001, 1'b0},
      '{CMD_MOD,  32'hFFFF_FFFF, 32'h0001_0000, 1'b0, 1'b0, '0, 1'b0},
      '{CMD_EQ,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0001, 1'b0},
      '{CMD_GT,   32'h0000_0005, 32'h0000_0005, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_LT,   32'h0000_0005, 32'h0000_0005, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_LT,   32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0001, 1'b0},
      '{CMD_MIN,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0000_0000, 1'b0},
      '{CMD_MAX,  32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0},
      '{CMD_MAX,  32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b1, 32'h8000_0000, 1'b0},
      '{CMD_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0000_0000, 1'b0}
    };

    // Directed part; typed-in expectations are checked against the predictor too
    foreach (table_rows[i]) begin
      row = table_rows[i];
      if (row.known) begin
        pr = alu_predict(row.cmd, row.a, row.b, row.cin);
        if (pr.result !== row.res || pr.dz !== row.dz) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10)
            $display("ERROR: table row %0d exp %h dz %b, predicted %h dz %b",
                     i, row.res, row.dz, pr.result, pr.dz);
        end
      end
      send_req(row.cmd, row.a, row.b, row.cin);
    end
    // Sender pauses until every result is back
    wait_drained();

    // Random part over idle/stall phases
    for (int unsigned n = 0; n < RandItems; n++) begin
      phase = (n * 5) / RandItems;
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 48; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 48; end
        3:       begin idle_pct = 31; stall_pct = 31; end
        default: begin idle_pct = 0;  stall_pct = 0;  end
      endcase
      cmd = cmd_e'($urandom_range(15));
      a   = rand_operand();
      b   = rand_operand();
      if ((cmd == CMD_DIV || cmd == CMD_MOD) && $urandom_range(3) == 0)
        b = b >> $urandom_range(31);
      if ($urandom_range(9) == 0) b = a;
      send_req(cmd, a, b, $urandom_range(1));
    end

    // Drain and settle
    stall_pct = 0;
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    done = 1'b1;
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

### filelist.f
+incdir+rtl/core
rtl/core/uia_pkg.sv
rtl/core/uia_if.sv
rtl/core/uia_div_stage.sv
rtl/core/unsigned_integer_alu.sv
sim/tb_unsigned_integer_alu.sv
